@@ hw/rtl/rpds_pkg.sv @@
package rpds_pkg;

    localparam int GRAY_BITS = 8;
    localparam int RHS_W     = 34;
    localparam int CODE_W    = 16;
    localparam int COUNT_W   = 19;
    localparam int COORD_W   = 9;

    localparam logic [RHS_W-1:0]   RHS_SCALE  = 34'd260100;
    localparam logic [7:0]         ALPHA      = 8'hff;
    localparam logic [CODE_W-1:0]  CODE_FULL  = 16'hffff;

    localparam logic [14:0] RESET_SOURCE_WIDTH   = 15'd1024;
    localparam logic [14:0] RESET_SOURCE_HEIGHT  = 15'd1024;
    localparam logic [9:0]  RESET_PREVIEW_WIDTH  = 10'd512;
    localparam logic [9:0]  RESET_PREVIEW_HEIGHT = 10'd512;

    localparam logic [1:0] REG_SOURCE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_PREVIEW_WIDTH  = 2'd2;
    localparam logic [1:0] REG_PREVIEW_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        ST_START,
        ST_DIV,
        ST_LOAD,
        ST_RUN
    } rpds_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               done;
        logic [CODE_W-1:0]  min_code;
        logic [CODE_W-1:0]  max_code;
        logic [COUNT_W-1:0] count;
    } rpds_side_t;

    typedef struct packed {
        logic [GRAY_BITS-1:0] gray;
        logic [RHS_W-1:0]     rhs;
        rpds_side_t           side;
    } rpds_stage_t;

endpackage

@@ hw/rtl/rpds_gamma_cell.sv @@
module rpds_gamma_cell #(
    parameter int BIT = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  rpds_pkg::rpds_stage_t up_stage,
    input  logic                 down_take,
    output logic                 take,
    output logic                 valid,
    output rpds_pkg::rpds_stage_t stage
);

    logic                                 valid_reg;
    rpds_pkg::rpds_stage_t                stage_reg;
    rpds_pkg::rpds_stage_t                stage_next;
    logic [rpds_pkg::GRAY_BITS-1:0]       cand;
    logic [rpds_pkg::GRAY_BITS:0]         odd;
    logic [2*rpds_pkg::GRAY_BITS+1:0]     sq;
    logic [rpds_pkg::RHS_W-1:0]           lhs;

    assign take  = !valid_reg || down_take;
    assign valid = valid_reg;
    assign stage = stage_reg;

    // test candidate with this bit set: (2c-1)^2 * 65535 <= rhs
    always_comb
    begin
        cand = up_stage.gray | (rpds_pkg::GRAY_BITS'(1) << BIT);
        odd  = {cand, 1'b0} - (rpds_pkg::GRAY_BITS+1)'(1);
        sq   = {{(rpds_pkg::GRAY_BITS+1){1'b0}}, odd} *
               {{(rpds_pkg::GRAY_BITS+1){1'b0}}, odd};
        lhs  = {sq, 16'b0} - {16'b0, sq};
        stage_next = up_stage;
        if (lhs <= up_stage.rhs)
        begin
            stage_next.gray = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ hw/rtl/rpds_div.sv @@
module rpds_div #(
    parameter int SRC_W = 15,
    parameter int PRV_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SRC_W-1:0] dividend,
    input  logic [PRV_W-1:0] prv,
    output logic             busy,
    output logic [PRV_W:0]   den,
    output logic [SRC_W-1:0] init_pick,
    output logic [PRV_W:0]   init_rem,
    output logic [SRC_W-1:0] step_q,
    output logic [PRV_W:0]   step_r
);

    localparam int CNT_W = $clog2(SRC_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fin_reg, fin_next;
    logic [SRC_W-1:0] dvd_reg, dvd_next;
    logic [SRC_W-1:0] quo_reg, quo_next;
    logic [PRV_W:0]   rem_reg, rem_next;
    logic [PRV_W:0]   den_reg, den_next;
    logic [PRV_W+1:0] trial;
    logic             ge;
    logic [PRV_W+1:0] dbl;
    logic             carry;
    logic [SRC_W-1:0] init_pick_reg;
    logic [PRV_W:0]   init_rem_reg;
    logic [SRC_W-1:0] step_q_reg;
    logic [PRV_W:0]   step_r_reg;

    assign busy      = (cnt_reg != '0) || fin_reg;
    assign den       = den_reg;
    assign init_pick = init_pick_reg;
    assign init_rem  = init_rem_reg;
    assign step_q    = step_q_reg;
    assign step_r    = step_r_reg;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SRC_W-1]};
        ge       = trial >= {1'b0, den_reg};
        dbl      = {rem_reg, 1'b0};
        carry    = dbl >= {1'b0, den_reg};
        cnt_next = cnt_reg;
        fin_next = 1'b0;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(SRC_W);
            dvd_next = dividend;
            quo_next = '0;
            rem_next = '0;
            den_next = {prv, 1'b0};
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            fin_next = (cnt_reg == CNT_W'(1));
            dvd_next = {dvd_reg[SRC_W-2:0], 1'b0};
            quo_next = {quo_reg[SRC_W-2:0], ge};
            rem_next = (PRV_W+1)'(ge ? trial - {1'b0, den_reg} : trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (fin_reg)
        begin
            init_pick_reg <= quo_reg;
            init_rem_reg  <= rem_reg;
            step_q_reg    <= {quo_reg[SRC_W-2:0], carry};
            step_r_reg    <= (PRV_W+1)'(carry ? dbl - {1'b0, den_reg} : dbl);
        end
    end

endmodule

@@ hw/rtl/raw_preview_downscale_sqrt_gamma.sv @@
// Channel  Direction  Signals                                  Item
// raw      sink       raw_valid, raw_ready, raw_code           one source sample
// pixel    source     pixel_valid, pixel_ready, pixel_argb ..  one preview pixel
// apb      sink       psel, penable, pwrite, paddr, pwdata     register access
//
// One raw item is taken per cycle while raw_ready is high; unpicked samples give no pixel.
// A picked sample reaches pixel_valid through the entry register, which loads at
// its accepting edge, and then through 8 gray search cells, one gray bit a cell.
// After reset and after every register write, raw_ready stays low while the two
// serial dividers work out the column and row pick steps, one quotient bit a cycle.
// A stalled pixel holds its cell; earlier cells keep filling until the chain is full.
module raw_preview_downscale_sqrt_gamma #(
    parameter int MAX_SOURCE_EDGE  = 16384,
    parameter int MAX_PREVIEW_EDGE = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        raw_valid,
    output logic        raw_ready,
    input  logic [15:0] raw_code,
    output logic        pixel_valid,
    input  logic        pixel_ready,
    output logic [31:0] pixel_argb,
    output logic [8:0]  preview_x,
    output logic [8:0]  preview_y,
    output logic        frame_done,
    output logic [15:0] min_code,
    output logic [15:0] max_code,
    output logic [18:0] samples_taken
);

    localparam int SRC_W = $clog2(MAX_SOURCE_EDGE + 1);
    localparam int PRV_W = $clog2(MAX_PREVIEW_EDGE + 1);
    localparam int CELLS = rpds_pkg::GRAY_BITS;

    rpds_pkg::rpds_state_t state_reg, state_next;

    logic [14:0] cfg_sw_reg, cfg_sh_reg;
    logic [9:0]  cfg_pw_reg, cfg_ph_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    logic [SRC_W-1:0] eff_sw, eff_sh;
    logic [PRV_W-1:0] pw_clamp, ph_clamp, eff_pw, eff_ph;

    logic             div_start;
    logic             col_busy, row_busy;
    logic [PRV_W:0]   col_den, row_den;
    logic [SRC_W-1:0] col_init_pick, row_init_pick;
    logic [PRV_W:0]   col_init_rem, row_init_rem;
    logic [SRC_W-1:0] col_step_q, row_step_q;
    logic [PRV_W:0]   col_step_r, row_step_r;

    logic [SRC_W-1:0] src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [PRV_W-1:0] out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic [SRC_W-1:0] npc_reg, npc_next, npr_reg, npr_next;
    logic [PRV_W:0]   col_rem_reg, col_rem_next, row_rem_reg, row_rem_next;
    logic [15:0]      min_reg, min_next, max_reg, max_next;
    logic [18:0]      samples_reg, samples_next;

    logic [PRV_W+1:0] col_sum, row_sum;
    logic             col_carry, row_carry;
    logic [PRV_W:0]   col_rem_adv, row_rem_adv;
    logic [SRC_W-1:0] col_pick_adv, row_pick_adv;

    logic                  accept;
    logic                  picked;
    logic                  s0_valid_reg;
    rpds_pkg::rpds_stage_t s0_stage_reg, s0_stage_next;

    rpds_pkg::rpds_stage_t stage_w [0:CELLS];
    logic [CELLS:0]        valid_w;
    logic [CELLS:0]        take_w;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_comb
    begin
        unique case (cfg_index)
            rpds_pkg::REG_SOURCE_WIDTH:   prdata = {17'b0, cfg_sw_reg};
            rpds_pkg::REG_SOURCE_HEIGHT:  prdata = {17'b0, cfg_sh_reg};
            rpds_pkg::REG_PREVIEW_WIDTH:  prdata = {22'b0, cfg_pw_reg};
            rpds_pkg::REG_PREVIEW_HEIGHT: prdata = {22'b0, cfg_ph_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_sw_reg <= rpds_pkg::RESET_SOURCE_WIDTH;
            cfg_sh_reg <= rpds_pkg::RESET_SOURCE_HEIGHT;
            cfg_pw_reg <= rpds_pkg::RESET_PREVIEW_WIDTH;
            cfg_ph_reg <= rpds_pkg::RESET_PREVIEW_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rpds_pkg::REG_SOURCE_WIDTH:   cfg_sw_reg <= pwdata[14:0];
                rpds_pkg::REG_SOURCE_HEIGHT:  cfg_sh_reg <= pwdata[14:0];
                rpds_pkg::REG_PREVIEW_WIDTH:  cfg_pw_reg <= pwdata[9:0];
                rpds_pkg::REG_PREVIEW_HEIGHT: cfg_ph_reg <= pwdata[9:0];
            endcase
        end
    end

    // effective frame and preview sizes
    always_comb
    begin
        if (cfg_sw_reg == '0)
            eff_sw = SRC_W'(1);
        else if (32'(cfg_sw_reg) > 32'(MAX_SOURCE_EDGE))
            eff_sw = SRC_W'(MAX_SOURCE_EDGE);
        else
            eff_sw = SRC_W'(cfg_sw_reg);

        if (cfg_sh_reg == '0)
            eff_sh = SRC_W'(1);
        else if (32'(cfg_sh_reg) > 32'(MAX_SOURCE_EDGE))
            eff_sh = SRC_W'(MAX_SOURCE_EDGE);
        else
            eff_sh = SRC_W'(cfg_sh_reg);

        if (cfg_pw_reg == '0)
            pw_clamp = PRV_W'(1);
        else if (32'(cfg_pw_reg) > 32'(MAX_PREVIEW_EDGE))
            pw_clamp = PRV_W'(MAX_PREVIEW_EDGE);
        else
            pw_clamp = PRV_W'(cfg_pw_reg);

        if (cfg_ph_reg == '0)
            ph_clamp = PRV_W'(1);
        else if (32'(cfg_ph_reg) > 32'(MAX_PREVIEW_EDGE))
            ph_clamp = PRV_W'(MAX_PREVIEW_EDGE);
        else
            ph_clamp = PRV_W'(cfg_ph_reg);

        eff_pw = (32'(pw_clamp) < 32'(eff_sw)) ? pw_clamp : PRV_W'(eff_sw);
        eff_ph = (32'(ph_clamp) < 32'(eff_sh)) ? ph_clamp : PRV_W'(eff_sh);
    end

    // setup sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpds_pkg::ST_START: state_next = rpds_pkg::ST_DIV;
            rpds_pkg::ST_DIV:
            begin
                if (!col_busy && !row_busy)
                    state_next = rpds_pkg::ST_LOAD;
            end
            rpds_pkg::ST_LOAD:  state_next = rpds_pkg::ST_RUN;
            rpds_pkg::ST_RUN:   state_next = rpds_pkg::ST_RUN;
        endcase
        if (cfg_write)
            state_next = rpds_pkg::ST_START;
    end

    always_comb
    begin
        div_start = 1'b0;
        raw_ready = 1'b0;
        unique case (state_reg)
            rpds_pkg::ST_START: div_start = 1'b1;
            rpds_pkg::ST_DIV:   div_start = 1'b0;
            rpds_pkg::ST_LOAD:  div_start = 1'b0;
            rpds_pkg::ST_RUN:   raw_ready = take_w[0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rpds_pkg::ST_START;
        else
            state_reg <= state_next;
    end

    rpds_div #(
        .SRC_W (SRC_W),
        .PRV_W (PRV_W)
    ) u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (eff_sw),
        .prv       (eff_pw),
        .busy      (col_busy),
        .den       (col_den),
        .init_pick (col_init_pick),
        .init_rem  (col_init_rem),
        .step_q    (col_step_q),
        .step_r    (col_step_r)
    );

    rpds_div #(
        .SRC_W (SRC_W),
        .PRV_W (PRV_W)
    ) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (eff_sh),
        .prv       (eff_ph),
        .busy      (row_busy),
        .den       (row_den),
        .init_pick (row_init_pick),
        .init_rem  (row_init_rem),
        .step_q    (row_step_q),
        .step_r    (row_step_r)
    );

    // position tracking and running statistics
    assign accept = raw_valid && raw_ready;

    always_comb
    begin
        col_sum      = {1'b0, col_rem_reg} + {1'b0, col_step_r};
        col_carry    = col_sum >= {1'b0, col_den};
        col_rem_adv  = (PRV_W+1)'(col_carry ? col_sum - {1'b0, col_den} : col_sum);
        col_pick_adv = npc_reg + col_step_q + SRC_W'(col_carry);
        row_sum      = {1'b0, row_rem_reg} + {1'b0, row_step_r};
        row_carry    = row_sum >= {1'b0, row_den};
        row_rem_adv  = (PRV_W+1)'(row_carry ? row_sum - {1'b0, row_den} : row_sum);
        row_pick_adv = npr_reg + row_step_q + SRC_W'(row_carry);

        picked = (out_row_reg < eff_ph) && (out_col_reg < eff_pw) &&
                 (src_row_reg == npr_reg) && (src_col_reg == npc_reg);

        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        npc_next     = npc_reg;
        npr_next     = npr_reg;
        col_rem_next = col_rem_reg;
        row_rem_next = row_rem_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        samples_next = samples_reg;

        if (accept && picked)
        begin
            if (raw_code < min_reg)
                min_next = raw_code;
            if (raw_code > max_reg)
                max_next = raw_code;
            samples_next = samples_reg + 19'd1;
            out_col_next = out_col_reg + PRV_W'(1);
            if (out_col_reg + PRV_W'(1) < eff_pw)
            begin
                npc_next     = col_pick_adv;
                col_rem_next = col_rem_adv;
            end
            else
            begin
                npc_next     = eff_sw;
                col_rem_next = '0;
            end
        end

        s0_stage_next.gray          = '0;
        s0_stage_next.rhs           = rpds_pkg::RHS_W'({18'b0, raw_code} * rpds_pkg::RHS_SCALE);
        s0_stage_next.side.x        = rpds_pkg::COORD_W'(out_col_reg);
        s0_stage_next.side.y        = rpds_pkg::COORD_W'(out_row_reg);
        s0_stage_next.side.done     = (out_row_reg + PRV_W'(1) == eff_ph) &&
                                      (out_col_reg + PRV_W'(1) == eff_pw);
        s0_stage_next.side.min_code = min_next;
        s0_stage_next.side.max_code = max_next;
        s0_stage_next.side.count    = samples_next;

        if (accept)
        begin
            if (src_col_reg + SRC_W'(1) >= eff_sw)
            begin
                src_col_next = '0;
                if ((out_row_reg < eff_ph) && (src_row_reg == npr_reg))
                begin
                    out_row_next = out_row_reg + PRV_W'(1);
                    out_col_next = '0;
                    npc_next     = col_init_pick;
                    col_rem_next = col_init_rem;
                    if (out_row_reg + PRV_W'(1) < eff_ph)
                    begin
                        npr_next     = row_pick_adv;
                        row_rem_next = row_rem_adv;
                    end
                    else
                    begin
                        npr_next     = eff_sh;
                        row_rem_next = '0;
                    end
                end
                src_row_next = src_row_reg + SRC_W'(1);
            end
            else
            begin
                src_col_next = src_col_reg + SRC_W'(1);
            end
        end

        // restart the frame after setup and after the last source row
        if ((state_reg == rpds_pkg::ST_LOAD) ||
            (accept && (src_col_reg + SRC_W'(1) >= eff_sw) &&
             (src_row_reg + SRC_W'(1) >= eff_sh)))
        begin
            src_col_next = '0;
            src_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
            npc_next     = col_init_pick;
            npr_next     = row_init_pick;
            col_rem_next = col_init_rem;
            row_rem_next = row_init_rem;
            min_next     = rpds_pkg::CODE_FULL;
            max_next     = '0;
            samples_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            npc_reg     <= '0;
            npr_reg     <= '0;
            col_rem_reg <= '0;
            row_rem_reg <= '0;
            min_reg     <= rpds_pkg::CODE_FULL;
            max_reg     <= '0;
            samples_reg <= '0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            npc_reg     <= npc_next;
            npr_reg     <= npr_next;
            col_rem_reg <= col_rem_next;
            row_rem_reg <= row_rem_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            samples_reg <= samples_next;
        end
    end

    // entry register
    assign take_w[0]  = !s0_valid_reg || take_w[1];
    assign valid_w[0] = s0_valid_reg;
    assign stage_w[0] = s0_stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (take_w[0])
            s0_valid_reg <= accept && picked;
    end

    always_ff @(posedge clk)
    begin
        if (take_w[0])
            s0_stage_reg <= s0_stage_next;
    end

    // gray search chain, most significant bit first
    for (genvar j = 1; j <= CELLS; j++)
    begin : g_cell
        logic down_take;
        if (j == CELLS)
        begin : g_last
            assign down_take = pixel_ready;
        end
        else
        begin : g_mid
            assign down_take = take_w[j+1];
        end

        rpds_gamma_cell #(
            .BIT (CELLS - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (valid_w[j-1]),
            .up_stage  (stage_w[j-1]),
            .down_take (down_take),
            .take      (take_w[j]),
            .valid     (valid_w[j]),
            .stage     (stage_w[j])
        );
    end

    assign pixel_valid   = valid_w[CELLS];
    assign pixel_argb    = {rpds_pkg::ALPHA, stage_w[CELLS].gray,
                            stage_w[CELLS].gray, stage_w[CELLS].gray};
    assign preview_x     = stage_w[CELLS].side.x;
    assign preview_y     = stage_w[CELLS].side.y;
    assign frame_done    = stage_w[CELLS].side.done;
    assign min_code      = stage_w[CELLS].side.min_code;
    assign max_code      = stage_w[CELLS].side.max_code;
    assign samples_taken = stage_w[CELLS].side.count;

    a_src_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpds_pkg::ST_RUN) |->
            (src_col_reg < eff_sw) && (src_row_reg < eff_sh))
        else $error("source position outside frame");

    a_out_in_preview: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpds_pkg::ST_RUN) |->
            (out_col_reg <= eff_pw) && (out_row_reg <= eff_ph))
        else $error("preview position outside preview");

    a_stats_order: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (min_code <= max_code) && (samples_taken != '0))
        else $error("pixel statistics inconsistent");

endmodule
